@@ src/atsp_pkg.sv @@
`default_nettype none
package atsp_pkg;

	localparam int QueueDepth = 4;

	localparam logic [7:0] ChEsc = 8'h1b;
	localparam logic [7:0] ChBs  = 8'h08;
	localparam logic [7:0] ChCr  = 8'h0d;
	localparam logic [7:0] ChLf  = 8'h0a;
	localparam logic [7:0] ChSgr = 8'h6d;
	localparam logic [7:0] ChUp  = 8'h41;
	localparam logic [7:0] ChDn  = 8'h42;
	localparam logic [7:0] ChRt  = 8'h43;
	localparam logic [7:0] ChLt  = 8'h44;
	localparam logic [7:0] ChSep = 8'h3b;
	localparam logic [7:0] ChD0  = 8'h30;
	localparam logic [7:0] ChD9  = 8'h39;

	localparam logic [9:0] FieldMax = 10'd999;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_CURSOR = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_POS    = 2'd0,
		KIND_PUT    = 2'd1,
		KIND_ERASE  = 2'd2,
		KIND_SCROLL = 2'd3
	} kind_t;

	typedef struct packed {
		logic [3:0] fg;
		logic [3:0] bg;
		logic [7:0] attr;
		logic       bold;
		logic       blink;
		logic [3:0] cs;
	} sgr_t;

	typedef struct packed {
		logic       last;
		logic [7:0] ccol;
		logic [7:0] crow;
		logic       cmove;
		logic [3:0] cs;
		logic [7:0] attr;
		logic [7:0] chr;
		logic [7:0] col;
		logic [7:0] row;
		kind_t      kind;
	} res_t;

	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	localparam sgr_t SgrReset = '{fg: 4'd7, bg: 4'd0, attr: 8'h07, bold: 1'b0,
		blink: 1'b0, cs: 4'd0};

	function automatic logic [3:0] cmap(logic [3:0] c);
		logic [3:0] r;
		case (c)
			4'd0: r = 4'd0;   4'd1: r = 4'd4;   4'd2: r = 4'd2;   4'd3: r = 4'd6;
			4'd4: r = 4'd1;   4'd5: r = 4'd5;   4'd6: r = 4'd3;   4'd7: r = 4'd7;
			4'd8: r = 4'd8;   4'd9: r = 4'd12;  4'd10: r = 4'd10; 4'd11: r = 4'd14;
			4'd12: r = 4'd9;  4'd13: r = 4'd13; 4'd14: r = 4'd11; default: r = 4'd15;
		endcase
		return r;
	endfunction

	// One SGR parameter applied to a copy of the attribute state.
	function automatic sgr_t apply_sgr(sgr_t s, logic [9:0] a_in);
		logic [9:0] a;
		sgr_t       r;
		r = s;
		a = a_in;
		if ((s.bold && a >= 10'd30 && a <= 10'd37) || (s.blink && a >= 10'd40 && a <= 10'd47))
			a = a + 10'd60;
		if (a == 10'd0) begin
			r.fg = 4'd7;
			r.bg = 4'd0;
			r.attr = 8'h07;
			r.bold = 1'b0;
			r.blink = 1'b0;
		end else if (a == 10'd1) begin
			r.bold = 1'b1;
			r.fg = s.fg | 4'h8;
			r.attr = {s.attr[7:4], cmap(r.fg)};
		end else if (a == 10'd5) begin
			r.blink = 1'b1;
			r.bg = s.bg | 4'h8;
			r.attr = {cmap(r.bg), s.attr[3:0]};
		end else if (a >= 10'd10 && a <= 10'd19) begin
			r.cs = 4'(a - 10'd10);
		end else if (a >= 10'd30 && a <= 10'd37) begin
			r.fg = 4'(a - 10'd30);
			r.attr = {s.attr[7:4], cmap(r.fg)};
		end else if (a >= 10'd90 && a <= 10'd97) begin
			r.fg = 4'(a - 10'd82);
			r.attr = {s.attr[7:4], cmap(r.fg)};
		end else if (a >= 10'd40 && a <= 10'd47) begin
			r.bg = 4'(a - 10'd40);
			r.attr = {cmap(r.bg), s.attr[3:0]};
		end else if (a >= 10'd100 && a <= 10'd107) begin
			r.bg = 4'(a - 10'd92);
			r.attr = {cmap(r.bg), s.attr[3:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/atsp_front.sv @@
`default_nettype none
module atsp_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire logic [31:0]    item,
	input  wire logic [7:0]     scr_w,
	input  wire logic [7:0]     scr_h,
	input  wire logic           cur_en,
	output atsp_pkg::push_t     push
);
	import atsp_pkg::*;

	logic       in_seq_q, intro_q, fstop_q, pff_q;
	logic [9:0] fv_q, ffv_q;
	logic [7:0] row_q, col_q;
	sgr_t       sgr_q, pend_q;

	logic       in_seq_d, intro_d, fstop_d, pff_d;
	logic [9:0] fv_d, ffv_d;
	logic [7:0] row_d, col_d;
	sgr_t       sgr_d, pend_d;

	logic [7:0]  c, rw, ro, hmax, wmax;
	logic        lit, ansi, sl;
	logic [4:0]  ov;
	logic [9:0]  d;
	logic [10:0] sum;
	logic [13:0] acc;
	logic [8:0]  nxt, rend;
	logic        put, wrap, lfok, scr;
	logic [7:0]  nrow, ncol;
	res_t        rp, rs, rq;

	assign c    = item[7:0];
	assign lit  = item[8];
	assign ansi = item[9];
	assign sl   = item[10];
	assign ov   = item[15:11];
	assign rw   = item[23:16];
	assign ro   = item[31:24];
	assign hmax = (scr_h != 8'd0) ? scr_h - 8'd1 : 8'd0;
	assign wmax = (scr_w != 8'd0) ? scr_w - 8'd1 : 8'd0;

	always_comb begin
		in_seq_d = in_seq_q; intro_d = intro_q; fstop_d = fstop_q; pff_d = pff_q;
		fv_d = fv_q; ffv_d = ffv_q; row_d = row_q; col_d = col_q;
		sgr_d = sgr_q; pend_d = pend_q;
		push = '0;
		d = pff_q ? ffv_q : fv_q;
		sum = '0;
		acc = {1'b0, fv_q, 3'b0} + {3'b0, fv_q, 1'b0} + {6'b0, 8'(c - ChD0)};
		nxt = {1'b0, col_q} + 9'd1;
		rend = {1'b0, ro} + {1'b0, rw};
		put = (row_q < scr_h) && (col_q < scr_w);
		wrap = (nxt == rend);
		lfok = ({1'b0, row_q} + 9'd1 < {1'b0, scr_h}) || sl;
		scr = 1'b0;
		nrow = row_q;
		ncol = col_q;
		rp = '0; rs = '0; rq = '0;
		if (in_seq_q) begin
			if (c == ChSgr) begin
				sgr_d = apply_sgr(pend_q, fv_q);
				in_seq_d = 1'b0;
			end else if (c >= ChUp && c <= ChLt) begin
				in_seq_d = 1'b0;
				if (c == ChUp) begin
					row_d = ({2'b0, row_q} >= d) ? 8'({2'b0, row_q} - d) : 8'd0;
				end else if (c == ChDn) begin
					sum = {3'b0, row_q} + {1'b0, d};
					row_d = (sum > {3'b0, hmax}) ? hmax : sum[7:0];
				end else if (c == ChRt) begin
					sum = {3'b0, col_q} + {1'b0, d};
					col_d = (sum > {3'b0, wmax}) ? wmax : sum[7:0];
				end else begin
					col_d = ({2'b0, col_q} >= d) ? 8'({2'b0, col_q} - d) : 8'd0;
				end
			end else if (!intro_q) begin
				intro_d = 1'b1;
			end else if (c == ChSep) begin
				if (!pff_q) begin
					ffv_d = fv_q;
					pff_d = 1'b1;
				end
				pend_d = apply_sgr(pend_q, fv_q);
				fv_d = '0;
				fstop_d = 1'b0;
			end else if (c >= ChD0 && c <= ChD9 && !fstop_q) begin
				fv_d = (acc > {4'b0, FieldMax}) ? FieldMax : acc[9:0];
			end else begin
				fstop_d = 1'b1;
			end
		end else if (c == ChEsc && !lit) begin
			in_seq_d = 1'b1; intro_d = 1'b0; fv_d = '0; fstop_d = 1'b0;
			ffv_d = '0; pff_d = 1'b0; pend_d = sgr_q;
		end else if (c == ChBs && !lit && !ansi) begin
			if (col_q != 8'd0) begin
				col_d = col_q - 8'd1;
				push.v0 = 1'b1;
				push.r0.kind = KIND_ERASE;
				push.r0.row = row_q;
				push.r0.col = col_d;
				push.r0.attr = sgr_q.attr;
				push.r0.cmove = cur_en;
				push.r0.crow = cur_en ? row_q : 8'd0;
				push.r0.ccol = cur_en ? col_d : 8'd0;
				push.r0.last = 1'b1;
			end
		end else if (c == ChCr && !lit) begin
			col_d = ro;
		end else if (c == ChLf && !lit) begin
			if (lfok) begin
				row_d = (row_q != 8'hff) ? row_q + 8'd1 : row_q;
			end else begin
				push.v0 = 1'b1;
				push.r0.kind = KIND_SCROLL;
				push.r0.last = 1'b1;
			end
		end else begin
			// Printable: put, optional wrap and scroll, cursor on the last beat.
			if (wrap) begin
				ncol = ro;
				if (lfok) nrow = (row_q != 8'hff) ? row_q + 8'd1 : row_q;
				else scr = 1'b1;
			end else begin
				ncol = nxt[8] ? 8'hff : nxt[7:0];
			end
			row_d = nrow;
			col_d = ncol;
			rp.kind = KIND_PUT;
			rp.row = row_q;
			rp.col = col_q;
			rp.chr = c;
			rp.attr = sgr_q.attr;
			rp.cs = ov[4] ? sgr_q.cs : ov[3:0];
			rs.kind = KIND_SCROLL;
			rq.kind = KIND_POS;
			rq.cmove = cur_en;
			rq.crow = cur_en ? ((nrow >= scr_h) ? hmax : nrow) : 8'd0;
			rq.ccol = cur_en ? ((ncol >= scr_w) ? wmax : ncol) : 8'd0;
			rq.last = 1'b1;
			if (put && scr) begin
				push.v0 = 1'b1; push.r0 = rp;
				push.v1 = 1'b1; push.r1 = rs;
				{push.r1.cmove, push.r1.crow, push.r1.ccol, push.r1.last} =
					{rq.cmove, rq.crow, rq.ccol, 1'b1};
			end else if (put || scr) begin
				push.v0 = 1'b1;
				push.r0 = put ? rp : rs;
				{push.r0.cmove, push.r0.crow, push.r0.ccol, push.r0.last} =
					{rq.cmove, rq.crow, rq.ccol, 1'b1};
			end else if (cur_en) begin
				push.v0 = 1'b1; push.r0 = rq;
			end
		end
		if (!take) push = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seq_q <= 1'b0; intro_q <= 1'b0; fstop_q <= 1'b0; pff_q <= 1'b0;
			fv_q <= '0; ffv_q <= '0; row_q <= '0; col_q <= '0;
			sgr_q <= SgrReset; pend_q <= SgrReset;
		end else if (take) begin
			in_seq_q <= in_seq_d; intro_q <= intro_d; fstop_q <= fstop_d; pff_q <= pff_d;
			fv_q <= fv_d; ffv_q <= ffv_d; row_q <= row_d; col_q <= col_d;
			sgr_q <= sgr_d; pend_q <= pend_d;
		end
	end

endmodule
`default_nettype wire

@@ src/atsp_queue.sv @@
`default_nettype none
module atsp_queue #(
	parameter int Depth = atsp_pkg::QueueDepth
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  atsp_pkg::push_t      push,
	output logic                 room,
	output logic                 valid,
	input  wire logic            pop,
	output atsp_pkg::res_t       head
);
	import atsp_pkg::*;

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	res_t          mem [Depth];
	logic [PW-1:0] wr_q, rd_q, wr1, wr_n, rd_n;
	logic [CW-1:0] cnt_q;
	logic          pop_ok;

	function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
		return (p == PW'(Depth - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr1    = inc(wr_q);
	assign wr_n   = push.v1 ? inc(wr1) : (push.v0 ? wr1 : wr_q);
	assign rd_n   = inc(rd_q);
	assign valid  = (cnt_q != '0);
	assign room   = (cnt_q <= CW'(Depth - 2));
	assign pop_ok = pop && valid;
	assign head   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.v0) mem[wr_q] <= push.r0;
		if (push.v1) mem[wr1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_n;
			if (pop_ok) rd_q <= rd_n;
			cnt_q <= cnt_q + CW'(push.v0) + CW'(push.v1) - CW'(pop_ok);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Depth)) else $error("queue count exceeds depth");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> push.v0) else $error("second push without first");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> room) else $error("push into a full queue");

endmodule
`default_nettype wire

@@ src/ansi_terminal_stream_parser.sv @@
`default_nettype none
// An accepted beat's results are registered in the result queue before they leave on m_*.
// Throughput: one input beat per cycle while the result queue has room for two
// results; the output drains one result beat per cycle while m_tready is high, so
// inputs that make two results are limited by the single output port.
// Reset (arst_n low, asynchronous): parser idle, cursor at 0,0, grey on black,
// charset 0, queue empty; registers return to 80 columns, 25 rows, cursor on.
module ansi_terminal_stream_parser #(
	parameter int QueueDepth = atsp_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// ch, literal_mode, ansi_mode, scroll_lock, charset_override,
	// region_width, region_offset
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// row, col, char_out, attributes, charset_out, cursor_move,
	// cursor_row, cursor_col, three zero bits
	output logic [55:0]      m_tdata,
	// kind
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);
	import atsp_pkg::*;

	logic [7:0] scr_w_q, scr_h_q;
	logic       cur_en_q;
	logic       take, room;
	push_t      push;
	res_t       head;

	// Configuration writes land directly; the user must write them only while idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= 8'd80;
			scr_h_q <= 8'd25;
			cur_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_WIDTH:  scr_w_q <= cfg_wdata;
				CFG_HEIGHT: scr_h_q <= cfg_wdata;
				CFG_CURSOR: cur_en_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// The front end only needs room for the worst case of two results.
	assign s_tready = room;
	assign take     = s_tvalid && room;

	atsp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (s_tdata),
		.scr_w  (scr_w_q),
		.scr_h  (scr_h_q),
		.cur_en (cur_en_q),
		.push   (push)
	);

	atsp_queue #(.Depth(QueueDepth)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (m_tvalid),
		.pop    (m_tready),
		.head   (head)
	);

	assign m_tuser = head.kind;
	assign m_tlast = head.last;
	assign m_tdata = {3'b000, head.ccol, head.crow, head.cmove, head.cs, head.attr,
		head.chr, head.col, head.row};

endmodule
`default_nettype wire

@@ sim/ansi_terminal_stream_parser_tb.sv @@
`timescale 1ns / 1ps

module ansi_terminal_stream_parser_tb;
	import atsp_pkg::*;

	// A run that takes more cycles than this is treated as hung.
	localparam int CycleLimit = 1000000;

	typedef struct {
		logic [7:0] ch;
		logic       lit;
		logic       ansi;
		logic       sl;
		logic [4:0] ov;
		logic [7:0] rw;
		logic [7:0] ro;
	} char_beat_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] chr;
		logic [7:0] attr;
		logic [3:0] cs;
		logic       cmove;
		logic [7:0] crow;
		logic [7:0] ccol;
		logic       last;
	} cell_op_t;

	typedef struct {
		int fg;
		int bg;
		int attr;
		int bold;
		int blink;
		int cs;
	} attr_state_t;

	// The scoreboard tracks the parser's state on its own and keeps the results
	// that every accepted character beat should still produce, oldest first.
	class terminal_scoreboard;
		int width = 80;
		int height = 25;
		int cursor_on = 1;
		int in_seq, intro_seen, field, field_stop, first_field, past_first;
		int row, col;
		attr_state_t sgr, pend;
		cell_op_t pending_ops[$];
		int mismatches;
		int received;
		int colour_map[16] = '{0, 4, 2, 6, 1, 5, 3, 7, 8, 12, 10, 14, 9, 13, 11, 15};

		function new();
			sgr = '{fg: 7, bg: 0, attr: 8'h07, bold: 0, blink: 0, cs: 0};
			pend = sgr;
		endfunction

		function void set_reg(cfg_idx_t idx, int value);
			case (idx)
				CFG_WIDTH:  width = value & 8'hff;
				CFG_HEIGHT: height = value & 8'hff;
				CFG_CURSOR: cursor_on = value & 1;
				default: ;
			endcase
		endfunction

		function attr_state_t apply_attr(attr_state_t s, int a);
			if ((s.bold && a >= 30 && a <= 37) || (s.blink && a >= 40 && a <= 47))
				a += 60;
			if (a == 0) begin
				s = '{fg: 7, bg: 0, attr: 8'h07, bold: 0, blink: 0, cs: s.cs};
			end else if (a == 1) begin
				s.bold = 1;
				s.fg = s.fg | 8;
				s.attr = (s.attr & 8'hf0) + colour_map[s.fg];
			end else if (a == 5) begin
				s.blink = 1;
				s.bg = s.bg | 8;
				s.attr = (s.attr & 8'h0f) + (colour_map[s.bg] << 4);
			end else if (a >= 10 && a <= 19) begin
				s.cs = a - 10;
			end else if ((a >= 30 && a <= 37) || (a >= 90 && a <= 97)) begin
				s.fg = (a >= 90) ? a - 82 : a - 30;
				s.attr = (s.attr & 8'hf0) + colour_map[s.fg];
			end else if ((a >= 40 && a <= 47) || (a >= 100 && a <= 107)) begin
				s.bg = (a >= 100) ? a - 92 : a - 40;
				s.attr = (s.attr & 8'h0f) + (colour_map[s.bg] << 4);
			end
			return s;
		endfunction

		// Moves down one line; returns 1 when the screen has to scroll instead.
		function int next_line(logic sl);
			if (row + 1 < height || sl) begin
				if (row < 255)
					row++;
				return 0;
			end
			return 1;
		endfunction

		function cell_op_t blank_op(kind_t k);
			cell_op_t op;
			op = '{kind: k, row: 0, col: 0, chr: 0, attr: 0, cs: 0, cmove: 0,
				crow: 0, ccol: 0, last: 0};
			return op;
		endfunction

		function void note_char(char_beat_t b);
			int hmax, wmax, d, nxt;
			cell_op_t ops[$];
			cell_op_t op;
			hmax = height ? height - 1 : 0;
			wmax = width ? width - 1 : 0;
			if (in_seq) begin
				if (b.ch == ChSgr) begin
					pend = apply_attr(pend, field);
					sgr = pend;
					in_seq = 0;
				end else if (b.ch >= ChUp && b.ch <= ChLt) begin
					d = past_first ? first_field : field;
					case (b.ch)
						ChUp: row = row >= d ? row - d : 0;
						ChDn: row = row + d > hmax ? hmax : row + d;
						ChRt: col = col + d > wmax ? wmax : col + d;
						default: col = col >= d ? col - d : 0;
					endcase
					in_seq = 0;
				end else if (!intro_seen) begin
					intro_seen = 1;
				end else if (b.ch == ChSep) begin
					if (!past_first) begin
						first_field = field;
						past_first = 1;
					end
					pend = apply_attr(pend, field);
					field = 0;
					field_stop = 0;
				end else if (b.ch >= ChD0 && b.ch <= ChD9 && !field_stop) begin
					field = field * 10 + (b.ch - ChD0);
					if (field > 999)
						field = 999;
				end else begin
					field_stop = 1;
				end
				return;
			end
			if (b.ch == ChEsc && !b.lit) begin
				in_seq = 1;
				intro_seen = 0;
				field = 0;
				field_stop = 0;
				first_field = 0;
				past_first = 0;
				pend = sgr;
				return;
			end
			if (b.ch == ChBs && !b.lit && !b.ansi) begin
				if (col == 0)
					return;
				col--;
				op = blank_op(KIND_ERASE);
				op.row = row;
				op.col = col;
				op.attr = sgr.attr;
				if (cursor_on) begin
					op.cmove = 1;
					op.crow = row;
					op.ccol = col;
				end
				op.last = 1;
				pending_ops.push_back(op);
				return;
			end
			if (b.ch == ChCr && !b.lit) begin
				col = b.ro;
				return;
			end
			if (b.ch == ChLf && !b.lit) begin
				if (next_line(b.sl)) begin
					op = blank_op(KIND_SCROLL);
					op.last = 1;
					pending_ops.push_back(op);
				end
				return;
			end
			// Printable: drop the write when off screen, but still advance.
			if (row < height && col < width) begin
				op = blank_op(KIND_PUT);
				op.row = row;
				op.col = col;
				op.chr = b.ch;
				op.attr = sgr.attr;
				op.cs = b.ov[4] ? sgr.cs : b.ov[3:0];
				ops.push_back(op);
			end
			nxt = col + 1;
			if (nxt == b.ro + b.rw) begin
				col = b.ro;
				if (next_line(b.sl))
					ops.push_back(blank_op(KIND_SCROLL));
			end else begin
				col = nxt > 255 ? 255 : nxt;
			end
			if (cursor_on) begin
				if (ops.size() == 0)
					ops.push_back(blank_op(KIND_POS));
				ops[$].cmove = 1;
				ops[$].crow = row >= height ? hmax : row;
				ops[$].ccol = col >= width ? wmax : col;
			end
			if (ops.size() > 0)
				ops[$].last = 1;
			foreach (ops[i])
				pending_ops.push_back(ops[i]);
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("MISMATCH at %0t: %s", $time, what);
		endfunction

		function void check_beat(logic [1:0] user, logic [55:0] data, logic tlast);
			cell_op_t e;
			received++;
			if (pending_ops.size() == 0) begin
				report($sformatf("unexpected result beat kind %0d data %h", user, data));
				return;
			end
			e = pending_ops.pop_front();
			if (user != e.kind)
				report($sformatf("kind %0d, expected %0d", user, e.kind));
			if (data[7:0] != e.row)
				report($sformatf("row %0d, expected %0d", data[7:0], e.row));
			if (data[15:8] != e.col)
				report($sformatf("col %0d, expected %0d", data[15:8], e.col));
			if (data[23:16] != e.chr)
				report($sformatf("char %h, expected %h", data[23:16], e.chr));
			if (data[31:24] != e.attr)
				report($sformatf("attributes %h, expected %h", data[31:24], e.attr));
			if (data[35:32] != e.cs)
				report($sformatf("charset %0d, expected %0d", data[35:32], e.cs));
			if (data[36] != e.cmove)
				report($sformatf("cursor_move %0d, expected %0d", data[36], e.cmove));
			if (data[44:37] != e.crow)
				report($sformatf("cursor_row %0d, expected %0d", data[44:37], e.crow));
			if (data[52:45] != e.ccol)
				report($sformatf("cursor_col %0d, expected %0d", data[52:45], e.ccol));
			if (tlast != e.last)
				report($sformatf("last %0d, expected %0d", tlast, e.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	terminal_scoreboard board;
	int  cycles;
	int  sent_chars;
	int  seq_count;
	bit  quiet;
	// Region used by most beats of a phase, so wraps actually happen.
	logic [7:0] phase_rw, phase_ro;

	ansi_terminal_stream_parser DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Watchdog: a stalled handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Outputs only change at rising edges, so the falling edge sees the values
	// that the next rising edge will accept.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_beat(m_tuser, m_tdata, m_tlast);
	end

	// The receiver stalls in random bursts, except in the closing stretch.
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				n = $urandom_range(1, 20);
			end else begin
				m_tready <= 1'b0;
				n = $urandom_range(1, 11);
			end
			repeat (n) @(posedge clk);
		end
	end

	task automatic send_char(char_beat_t b);
		bit ok;
		s_tdata <= {b.ro, b.rw, b.ov, b.sl, b.ansi, b.lit, b.ch};
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		board.note_char(b);
		sent_chars++;
		// A random gap between beats, never in the closing stretch.
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Builds a beat around one character with random mode fields.
	function automatic char_beat_t make_beat(logic [7:0] ch);
		char_beat_t b;
		b.ch = ch;
		b.lit = ($urandom_range(0, 15) == 0);
		b.ansi = ($urandom_range(0, 4) == 0);
		b.sl = ($urandom_range(0, 3) == 0);
		b.ov = ($urandom_range(0, 1) == 0) ? 5'h1f : 5'($urandom);
		if ($urandom_range(0, 9) != 0) begin
			b.rw = phase_rw;
			b.ro = phase_ro;
		end else begin
			b.rw = 8'($urandom_range(1, 255));
			b.ro = 8'($urandom_range(0, 254));
		end
		return b;
	endfunction

	// A character beat with plain modes, for the directed part.
	task automatic send_plain(logic [7:0] ch);
		char_beat_t b;
		b = '{ch: ch, lit: 0, ansi: 0, sl: 0, ov: 5'h1f, rw: phase_rw, ro: phase_ro};
		send_char(b);
	endtask

	task automatic send_text(string s);
		foreach (s[i])
			send_plain(s[i]);
	endtask

	// Waits until no result is owed, then lets any in-flight beat settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending_ops.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, value);
	endtask

	task automatic set_screen(int w, int h, int cur);
		drain();
		write_reg(CFG_WIDTH, 8'(w));
		write_reg(CFG_HEIGHT, 8'(h));
		write_reg(CFG_CURSOR, 8'(cur));
	endtask

	// A well-formed escape sequence with random parameters. Now and then the
	// introducer is odd, a field is broken by a stray character, or the
	// sequence is left open so that following text lands inside it.
	task automatic send_sequence();
		int nf, v, pick;
		string s;
		logic [7:0] term;
		send_char(make_beat(ChEsc));
		send_char(make_beat(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h5b));
		nf = $urandom_range(0, 4);
		for (int f = 0; f < nf; f++) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				case ($urandom_range(0, 5))
					0: v = $urandom_range(0, 5);
					1: v = $urandom_range(10, 19);
					2: v = $urandom_range(30, 37);
					3: v = $urandom_range(40, 47);
					4: v = $urandom_range(90, 97);
					default: v = $urandom_range(100, 107);
				endcase
			end else if (pick < 9) begin
				v = $urandom_range(0, 300);
			end else begin
				v = $urandom_range(999, 99999);
			end
			s = $sformatf("%0d", v);
			if ($urandom_range(0, 11) == 0)
				s = {s.substr(0, 0), ($urandom_range(0, 1) ? " " : "-"), s};
			foreach (s[i])
				send_char(make_beat(s[i]));
			if (f != nf - 1)
				send_char(make_beat(ChSep));
		end
		pick = $urandom_range(0, 9);
		if (pick < 6)
			term = ChSgr;
		else if (pick < 9)
			term = 8'($urandom_range(ChUp, ChLt));
		else
			return;
		send_char(make_beat(term));
		seq_count++;
	endtask

	// Plain text with line controls and an occasional arbitrary byte.
	task automatic send_run();
		int n;
		logic [7:0] ch;
		n = $urandom_range(1, 12);
		repeat (n) begin
			case ($urandom_range(0, 15))
				0: ch = ChCr;
				1, 2: ch = ChLf;
				3, 4: ch = ChBs;
				5: ch = 8'($urandom);
				default: ch = 8'($urandom_range(8'h20, 8'h7e));
			endcase
			send_char(make_beat(ch));
		end
	endtask

	task automatic random_phase(int count);
		int start;
		start = sent_chars;
		while (sent_chars - start < count) begin
			if ($urandom_range(0, 2) == 0)
				send_sequence();
			else
				send_run();
		end
	endtask

	initial begin
		char_beat_t b;
		board = new();
		cycles = 0;
		sent_chars = 0;
		seq_count = 0;
		quiet = 0;
		phase_rw = 8'd80;
		phase_ro = 8'd0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = CFG_WIDTH;
		cfg_wdata = 8'd0;
		s_tvalid = 1'b0;
		s_tdata = 32'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: backspace at column zero, attributes, charsets, clamped
		// moves, a stopped field, an escape that ends at its introducer.
		send_plain(ChBs);
		send_text("\033[1;5;31;44mA");
		send_text("\033[15mB");
		send_text("\033[0;97;107m");
		send_text("\033[9999B\033[3x4C");
		send_text("\033m");
		send_plain(ChBs);
		send_plain(ChLf);
		b = '{ch: ChEsc, lit: 1, ansi: 1, sl: 1, ov: 5'd3, rw: 8'd255, ro: 8'd254};
		send_char(b);
		b = '{ch: 8'hff, lit: 0, ansi: 1, sl: 0, ov: 5'd15, rw: 8'd1, ro: 8'd0};
		send_char(b);
		send_plain(ChCr);

		// Hold back until every owed result has arrived, mid-phase.
		s_tvalid <= 1'b0;
		while (board.pending_ops.size() != 0)
			@(posedge clk);

		phase_rw = 8'd20;
		phase_ro = 8'd3;
		random_phase(250);

		set_screen(1, 1, 0);
		phase_rw = 8'd1;
		phase_ro = 8'd0;
		random_phase(150);

		set_screen(255, 255, 1);
		phase_rw = 8'd255;
		phase_ro = 8'd0;
		random_phase(250);

		set_screen(12, 4, 1);
		phase_rw = 8'd12;
		phase_ro = 8'd0;
		random_phase(250);

		set_screen($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 1));
		phase_rw = 8'($urandom_range(1, 60));
		phase_ro = 8'($urandom_range(0, 30));
		random_phase(250);

		// Closing stretch without any idling on either side.
		quiet = 1;
		random_phase(150);

		s_tvalid <= 1'b0;
		while (board.pending_ops.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d character beats (%0d terminated escape sequences), checked %0d results",
			sent_chars, seq_count, board.received);
		$display("over five screen settings including 1x1 and 255x255, cursor reports on and off.");
		if (board.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ ansi_terminal_stream_parser.f @@
src/atsp_pkg.sv
src/atsp_front.sv
src/atsp_queue.sv
src/ansi_terminal_stream_parser.sv
sim/ansi_terminal_stream_parser_tb.sv
